### rtl/core/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants, codes and helpers for the line pixel rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Default coordinate width
  localparam int LPR_COORD_WIDTH = 10;

  // Color formats
  localparam int RGB_WIDTH   = 24;
  localparam int COLOR_WIDTH = 16;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FOREGROUND = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BACKGROUND = 2'd1;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Control of one registered item handed to the step unit
  typedef struct packed {
    logic valid;
    logic op;
    logic erase;
  } lpr_item_ctrl_t;

  // Convert 24-bit RGB (red in top byte) to RGB565
  function automatic logic [COLOR_WIDTH-1:0] to565(input logic [RGB_WIDTH-1:0] rgb);
    to565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

### rtl/core/lpr_setup.sv
// ----------------------------------------------------------------------------
// lpr_setup
// Line setup: pick the major axis, order endpoints and derive the spans.
// ----------------------------------------------------------------------------
module lpr_setup #(
  parameter int COORD_WIDTH = lpr_pkg::LPR_COORD_WIDTH
) (
  input  logic [COORD_WIDTH-1:0] start_x,
  input  logic [COORD_WIDTH-1:0] start_y,
  input  logic [COORD_WIDTH-1:0] end_x,
  input  logic [COORD_WIDTH-1:0] end_y,
  output logic                   steep,
  output logic [COORD_WIDTH-1:0] major_start,
  output logic [COORD_WIDTH-1:0] major_stop,
  output logic [COORD_WIDTH-1:0] minor_start,
  output logic [COORD_WIDTH-1:0] major_len,
  output logic [COORD_WIDTH-1:0] minor_len,
  output logic                   down
);

  logic [COORD_WIDTH-1:0] dx;
  logic [COORD_WIDTH-1:0] dy;
  logic [COORD_WIDTH-1:0] a1;
  logic [COORD_WIDTH-1:0] a2;
  logic [COORD_WIDTH-1:0] b1;
  logic [COORD_WIDTH-1:0] b2;
  logic                   swap;
  logic [COORD_WIDTH-1:0] bs;
  logic [COORD_WIDTH-1:0] be;

  // Span on each axis
  assign dx = (start_x > end_x) ? start_x - end_x : end_x - start_x;
  assign dy = (start_y > end_y) ? start_y - end_y : end_y - start_y;
  assign steep = dy > dx;

  // Swap axes for steep lines
  assign a1 = steep ? start_y : start_x;
  assign b1 = steep ? start_x : start_y;
  assign a2 = steep ? end_y   : end_x;
  assign b2 = steep ? end_x   : end_y;

  // Order endpoints so the major coordinate rises
  assign swap        = a1 > a2;
  assign major_start = swap ? a2 : a1;
  assign major_stop  = swap ? a1 : a2;
  assign bs          = swap ? b2 : b1;
  assign be          = swap ? b1 : b2;
  assign minor_start = bs;

  assign major_len = major_stop - major_start;
  assign minor_len = (bs > be) ? bs - be : be - bs;
  assign down      = !(bs < be);

endmodule

### rtl/core/lpr_step.sv
// ----------------------------------------------------------------------------
// lpr_step
// Line state, one Bresenham step per step item and the result register.
// ----------------------------------------------------------------------------
module lpr_step #(
  parameter int COORD_WIDTH = lpr_pkg::LPR_COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lpr_pkg::lpr_item_ctrl_t          item,
  output logic                             item_ready,
  input  logic                             set_steep,
  input  logic [COORD_WIDTH-1:0]           set_major_pos,
  input  logic [COORD_WIDTH-1:0]           set_major_end,
  input  logic [COORD_WIDTH-1:0]           set_minor_pos,
  input  logic [COORD_WIDTH-1:0]           set_major_span,
  input  logic [COORD_WIDTH-1:0]           set_minor_span,
  input  logic                             set_minor_down,
  input  logic [lpr_pkg::RGB_WIDTH-1:0]    fg_rgb,
  input  logic [lpr_pkg::RGB_WIDTH-1:0]    bg_rgb,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COORD_WIDTH-1:0]           pixel_x,
  output logic [COORD_WIDTH-1:0]           pixel_y,
  output logic [lpr_pkg::COLOR_WIDTH-1:0]  color565,
  output logic                             last
);

  localparam int EW = COORD_WIDTH + 2;

  logic                   busy;
  logic                   steep_flag;
  logic                   minor_down;
  logic                   erase_flag;
  logic [COORD_WIDTH-1:0] major_pos;
  logic [COORD_WIDTH-1:0] major_end;
  logic [COORD_WIDTH-1:0] minor_pos;
  logic [COORD_WIDTH-1:0] major_span;
  logic [COORD_WIDTH-1:0] minor_span;
  logic signed [EW-1:0]   error_term;

  logic                   is_step;
  logic                   out_free;
  logic                   fire;
  logic                   emit;
  logic                   start;
  logic [COORD_WIDTH-1:0] major_pos_next;
  logic [COORD_WIDTH-1:0] minor_pos_next;
  logic signed [EW-1:0]   err_sub;
  logic signed [EW-1:0]   err_add;
  logic signed [EW-1:0]   error_term_next;
  logic                   fin;

  // Handshake toward the input register
  assign is_step    = (item.op == lpr_pkg::OP_STEP) && busy;
  assign out_free   = !out_valid || !out_stall;
  assign item_ready = out_free || !is_step;
  assign fire       = item.valid && item_ready;
  assign emit       = fire && is_step;
  assign start      = fire && (item.op == lpr_pkg::OP_START);

  // Advance the error term and coordinates
  assign major_pos_next  = major_pos + COORD_WIDTH'(1);
  assign fin             = major_pos_next == major_end;
  assign err_sub         = error_term - $signed({1'b0, minor_span, 1'b0});
  assign err_add         = err_sub + $signed({1'b0, major_span, 1'b0});
  assign error_term_next = err_sub[EW-1] ? err_add : err_sub;
  assign minor_pos_next  = !err_sub[EW-1] ? minor_pos :
                           (minor_down ? minor_pos - COORD_WIDTH'(1)
                                       : minor_pos + COORD_WIDTH'(1));

  // Hold line state; load on start, advance on step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      steep_flag <= 1'b0;
      minor_down <= 1'b0;
      erase_flag <= 1'b0;
      major_pos  <= '0;
      major_end  <= '0;
      minor_pos  <= '0;
      major_span <= '0;
      minor_span <= '0;
      error_term <= '0;
    end else if (start) begin
      busy       <= set_major_span != '0;
      steep_flag <= set_steep;
      minor_down <= set_minor_down;
      erase_flag <= item.erase;
      major_pos  <= set_major_pos;
      major_end  <= set_major_end;
      minor_pos  <= set_minor_pos;
      major_span <= set_major_span;
      minor_span <= set_minor_span;
      error_term <= $signed({2'b00, set_major_span});
    end else if (emit) begin
      major_pos  <= major_pos_next;
      minor_pos  <= minor_pos_next;
      error_term <= error_term_next;
      if (fin) begin
        busy <= 1'b0;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x  <= steep_flag ? minor_pos : major_pos;
      pixel_y  <= steep_flag ? major_pos : minor_pos;
      color565 <= lpr_pkg::to565(erase_flag ? bg_rgb : fg_rgb);
      last     <= fin;
    end
  end

  // Checks
  a_busy_span: assert property (@(posedge clk) disable iff (rst)
    busy |-> (major_span != '0))
    else $error("busy with zero major span");

  a_err_nonneg: assert property (@(posedge clk) disable iff (rst)
    !error_term[EW-1])
    else $error("error term went negative");

  a_minor_le_major: assert property (@(posedge clk) disable iff (rst)
    minor_span <= major_span)
    else $error("minor span exceeds major span");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && fin) |=> (!busy && out_valid && last))
    else $error("line not closed after last pixel");

endmodule

### rtl/core/line_pixel_rasterizer_top.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_top
// Bresenham line rasterizer: start beats load a line, step beats emit pixels while it is active.
// ----------------------------------------------------------------------------
// Path: a step beat is captured in the input register, and its pixel is then
//   written into the result register that drives the outputs.
// Throughput: one beat per cycle; the input register advances whenever the
//   result register is free or the held beat yields no pixel.
// Reset: rst clears line state, colors and both valid flags; block is idle.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_top #(
  parameter int COORD_WIDTH = lpr_pkg::LPR_COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lpr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lpr_pkg::RGB_WIDTH-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [COORD_WIDTH-1:0]              start_x,
  input  logic [COORD_WIDTH-1:0]              start_y,
  input  logic [COORD_WIDTH-1:0]              end_x,
  input  logic [COORD_WIDTH-1:0]              end_y,
  input  logic                                erase,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [COORD_WIDTH-1:0]              pixel_x,
  output logic [COORD_WIDTH-1:0]              pixel_y,
  output logic [lpr_pkg::COLOR_WIDTH-1:0]     color565,
  output logic                                last
);

  logic [lpr_pkg::RGB_WIDTH-1:0] foreground_rgb;
  logic [lpr_pkg::RGB_WIDTH-1:0] background_rgb;

  logic                     s1_valid;
  logic                     s1_op;
  logic                     s1_erase;
  logic [COORD_WIDTH-1:0]   s1_start_x;
  logic [COORD_WIDTH-1:0]   s1_start_y;
  logic [COORD_WIDTH-1:0]   s1_end_x;
  logic [COORD_WIDTH-1:0]   s1_end_y;

  lpr_pkg::lpr_item_ctrl_t  item;
  logic                     item_ready;
  logic                     set_steep;
  logic [COORD_WIDTH-1:0]   set_major_pos;
  logic [COORD_WIDTH-1:0]   set_major_end;
  logic [COORD_WIDTH-1:0]   set_minor_pos;
  logic [COORD_WIDTH-1:0]   set_major_span;
  logic [COORD_WIDTH-1:0]   set_minor_span;
  logic                     set_minor_down;

  // Write color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      foreground_rgb <= '0;
      background_rgb <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lpr_pkg::REG_FOREGROUND: foreground_rgb <= cfg_data;
        lpr_pkg::REG_BACKGROUND: background_rgb <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stall the input while the held beat cannot move on
  assign in_stall = s1_valid && !item_ready;

  // Input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op      <= op;
      s1_erase   <= erase;
      s1_start_x <= start_x;
      s1_start_y <= start_y;
      s1_end_x   <= end_x;
      s1_end_y   <= end_y;
    end
  end

  assign item.valid = s1_valid;
  assign item.op    = s1_op;
  assign item.erase = s1_erase;

  lpr_setup #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_setup (
    .start_x     (s1_start_x),
    .start_y     (s1_start_y),
    .end_x       (s1_end_x),
    .end_y       (s1_end_y),
    .steep       (set_steep),
    .major_start (set_major_pos),
    .major_stop  (set_major_end),
    .minor_start (set_minor_pos),
    .major_len   (set_major_span),
    .minor_len   (set_minor_span),
    .down        (set_minor_down)
  );

  lpr_step #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_step (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .item_ready     (item_ready),
    .set_steep      (set_steep),
    .set_major_pos  (set_major_pos),
    .set_major_end  (set_major_end),
    .set_minor_pos  (set_minor_pos),
    .set_major_span (set_major_span),
    .set_minor_span (set_minor_span),
    .set_minor_down (set_minor_down),
    .fg_rgb         (foreground_rgb),
    .bg_rgb         (background_rgb),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .color565       (color565),
    .last           (last)
  );

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the line pixel rasterizer against a cycle-free line predictor. A
// queue-fed driver offers start and step beats with random gaps, a monitor
// compares every pixel beat field by field with the oldest predicted pixel,
// and the color registers are rewritten between phases once the block drains.
// ----------------------------------------------------------------------------
module testbench;
  import lpr_pkg::*;

  localparam int CW           = LPR_COORD_WIDTH;
  localparam int CMAX         = (1 << CW) - 1;
  localparam int MAX_GAP      = 4;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 150;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;

  // Indexes that decode to no register
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic          op;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic          erase;
  } line_cmd_t;

  typedef struct packed {
    logic [CW-1:0]          px;
    logic [CW-1:0]          py;
    logic [COLOR_WIDTH-1:0] color;
    logic                   fin;
  } pixel_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [RGB_WIDTH-1:0]       cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [CW-1:0]              pixel_x;
  logic [CW-1:0]              pixel_y;
  logic [COLOR_WIDTH-1:0]     color565;
  logic                       last;

  line_cmd_t cur_cmd = '0;
  line_cmd_t pending_cmds[$];
  pixel_t    line_pixels_due[$];
  pixel_t    want;

  logic no_idle = 1'b0;
  int   tx_wait;
  int   rx_wait;
  int   hold_left;
  int   pixels_seen = 0;
  int   cmds_queued = 0;
  int   errors = 0;
  int   idle_cycles = 0;

  // Predicted line state and colors
  logic [RGB_WIDTH-1:0] fg_rgb;
  logic [RGB_WIDTH-1:0] bg_rgb;
  logic [CW-1:0]        maj_pos;
  logic [CW-1:0]        maj_end;
  logic [CW-1:0]        min_pos;
  logic [CW-1:0]        maj_span;
  logic [CW-1:0]        min_span;
  logic signed [CW+1:0] err2;
  logic                 steep_q;
  logic                 down_q;
  logic                 erase_q;
  logic                 drawing;

  line_pixel_rasterizer_top #(
    .COORD_WIDTH(CW)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (cur_cmd.op),
    .start_x   (cur_cmd.sx),
    .start_y   (cur_cmd.sy),
    .end_x     (cur_cmd.ex),
    .end_y     (cur_cmd.ey),
    .erase     (cur_cmd.erase),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .color565  (color565),
    .last      (last)
  );

  always #1 clk = ~clk;

  function automatic logic [CW-1:0] gap_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advance the line state by one accepted beat; queue the pixel it emits
  function automatic void rasterize(input line_cmd_t c);
    logic [CW-1:0]        a1, b1, a2, b2, nxt;
    logic                 steep;
    logic [RGB_WIDTH-1:0] rgb;
    pixel_t               p;
    if (c.op == OP_START) begin
      steep = gap_of(c.sy, c.ey) > gap_of(c.sx, c.ex);
      a1 = steep ? c.sy : c.sx;
      b1 = steep ? c.sx : c.sy;
      a2 = steep ? c.ey : c.ex;
      b2 = steep ? c.ex : c.ey;
      if (a1 > a2) begin
        {a1, a2} = {a2, a1};
        {b1, b2} = {b2, b1};
      end
      steep_q  = steep;
      erase_q  = c.erase;
      maj_pos  = a1;
      maj_end  = a2;
      min_pos  = b1;
      maj_span = a2 - a1;
      min_span = gap_of(b1, b2);
      down_q   = !(b1 < b2);
      err2     = $signed({2'b00, maj_span});
      drawing  = (maj_span != 0);
    end else if (drawing) begin
      nxt     = maj_pos + 1'b1;
      rgb     = erase_q ? bg_rgb : fg_rgb;
      p.px    = steep_q ? min_pos : maj_pos;
      p.py    = steep_q ? maj_pos : min_pos;
      p.color = {rgb[23:19], rgb[15:10], rgb[7:3]};
      p.fin   = (nxt == maj_end);
      line_pixels_due.push_back(p);
      err2 = err2 - $signed({1'b0, min_span, 1'b0});
      if (err2 < 0) begin
        min_pos = down_q ? min_pos - 1'b1 : min_pos + 1'b1;
        err2    = err2 + $signed({1'b0, maj_span, 1'b0});
      end
      maj_pos = nxt;
      if (p.fin) drawing = 1'b0;
    end
  endfunction

  function automatic void report(input string field, input int exp_val, input int got_val);
    errors++;
    $display("%0t: %s expected %0d got %0d", $time, field, exp_val, got_val);
  endfunction

  function automatic void queue_line(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                                     input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                                     input logic er);
    line_cmd_t c;
    c.op    = OP_START;
    c.sx    = sx;
    c.sy    = sy;
    c.ex    = ex;
    c.ey    = ey;
    c.erase = er;
    pending_cmds.push_back(c);
    cmds_queued++;
  endfunction

  // Step beats carry random endpoint and erase bits, which the block ignores
  function automatic void queue_steps(input int n);
    line_cmd_t c;
    repeat (n) begin
      c.op    = OP_STEP;
      c.sx    = CW'($urandom);
      c.sy    = CW'($urandom);
      c.ex    = CW'($urandom);
      c.ey    = CW'($urandom);
      c.erase = 1'($urandom);
      pending_cmds.push_back(c);
      cmds_queued++;
    end
  endfunction

  // Pick a coordinate within reach of a base, clipped to the field range
  function automatic logic [CW-1:0] near(input logic [CW-1:0] base, input int reach);
    int lo, hi;
    lo = int'(base) - reach;
    hi = int'(base) + reach;
    if (lo < 0) lo = 0;
    if (hi > CMAX) hi = CMAX;
    return CW'($urandom_range(hi, lo));
  endfunction

  // Mostly short complete lines, some abandoned lines, some stray steps
  task automatic queue_random_lines(input int n_items);
    int            first, roll, reach, span, steps;
    logic [CW-1:0] sx, sy, ex, ey;
    first = cmds_queued;
    while (cmds_queued - first < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        queue_steps($urandom_range(1, 3));
      end else begin
        reach = (roll < 90) ? $urandom_range(0, 12) :
                (roll < 98) ? $urandom_range(13, 80) : CMAX;
        sx = CW'($urandom);
        sy = CW'($urandom);
        ex = near(sx, reach);
        ey = near(sy, reach);
        span = (gap_of(sx, ex) > gap_of(sy, ey)) ? int'(gap_of(sx, ex))
                                                 : int'(gap_of(sy, ey));
        queue_line(sx, sy, ex, ey, 1'($urandom_range(0, 1)));
        if (span > 80)
          steps = $urandom_range(1, 60);
        else if ($urandom_range(0, 9) < 7)
          steps = span + $urandom_range(0, 2);
        else
          steps = $urandom_range(0, span);
        queue_steps(steps);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [RGB_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOREGROUND: fg_rgb = val;
      REG_BACKGROUND: bg_rgb = val;
      default: ;
    endcase
  endtask

  // Wait until every beat is taken and every pixel has come back
  task automatic settle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || line_pixels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Driver: offer queued beats, hold each until taken, then wait a random gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && !in_stall) rasterize(cur_cmd);
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          tx_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each pixel beat, then stall for a random stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        pixels_seen++;
        if (line_pixels_due.size() == 0) begin
          report("unexpected pixel at x", -1, int'(pixel_x));
        end else begin
          want = line_pixels_due.pop_front();
          if (pixel_x !== want.px) report("pixel_x", int'(want.px), int'(pixel_x));
          if (pixel_y !== want.py) report("pixel_y", int'(want.py), int'(pixel_y));
          if (color565 !== want.color)
            report("color565", int'(want.color), int'(color565));
          if (last !== want.fin) report("last", int'(want.fin), int'(last));
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        // Back up the pipe once so the input side has to stall
        if (pixels_seen == HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    fg_rgb   = '0;
    bg_rgb   = '0;
    maj_pos  = '0;
    maj_end  = '0;
    min_pos  = '0;
    maj_span = '0;
    min_span = '0;
    err2     = '0;
    steep_q  = 1'b0;
    down_q   = 1'b0;
    erase_q  = 1'b0;
    drawing  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed lines with the reset colors
    queue_steps(1);                                   // step while idle
    queue_line(CW'(CMAX), CW'(CMAX), CW'(CMAX - 3), CW'(CMAX - 2),
               1'b0);                                 // reversed shallow line
    queue_steps(4);                                   // three pixels, one ignored
    queue_line(0, 0, 0, 0, 1'b1);                     // zero length
    queue_steps(1);
    queue_line(0, 0, 1, 4, 1'b1);                     // steep line
    queue_steps(2);
    queue_line(5, 9, 5, 5, 1'b0);                     // vertical, reversed, one step ignored
    queue_steps(5);
    queue_line(CW'(CMAX), 0, CW'(CMAX - 4), 0, 1'b1); // horizontal at the edges
    queue_steps(4);
    queue_line(0, CW'(CMAX), 3, CW'(CMAX - 1), 1'b0); // minor axis steps down
    queue_steps(3);
    settle();

    // Full foreground, empty background
    write_reg(REG_FOREGROUND, '1);
    write_reg(REG_BACKGROUND, '0);
    queue_random_lines(450);
    settle();

    // Swap the extremes, poke unused indexes, run without idling
    write_reg(REG_FOREGROUND, '0);
    write_reg(REG_BACKGROUND, '1);
    write_reg(REG_SPARE_LO, RGB_WIDTH'($urandom));
    write_reg(REG_SPARE_HI, RGB_WIDTH'($urandom));
    no_idle <= 1'b1;
    queue_random_lines(450);
    settle();

    // Random colors
    no_idle <= 1'b0;
    write_reg(REG_FOREGROUND, RGB_WIDTH'($urandom));
    write_reg(REG_BACKGROUND, RGB_WIDTH'($urandom));
    queue_random_lines(500);
    settle();

    write_reg(REG_BACKGROUND, RGB_WIDTH'($urandom));
    write_reg(REG_FOREGROUND, RGB_WIDTH'($urandom));
    queue_random_lines(500);
    settle();

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
